[rtl/hv_counter_irq_nmi_unit_defines.svh]
// Assertion macros for the video-counter interrupt unit checker.
// No dependencies; included by the checker file.
`ifndef HV_COUNTER_IRQ_NMI_UNIT_DEFINES_SVH
`define HV_COUNTER_IRQ_NMI_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define HVC_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("hvc assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define HVC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("hvc assertion failed");

`endif

[rtl/hvc_pkg.sv]
// Shared types and constants for the video-counter interrupt unit.
// No dependencies; used by every module of the block.
package hvc_pkg;

    typedef enum logic [2:0] {
        FUNC_POLL       = 3'd0,
        FUNC_ENABLE_WR  = 3'd1,
        FUNC_POS_WR     = 3'd2,
        FUNC_NMI_READ   = 3'd3,
        FUNC_IRQ_READ   = 3'd4,
        FUNC_NMI_TAKE   = 3'd5,
        FUNC_IRQ_TAKE   = 3'd6
    } func_t;

    typedef enum logic [1:0] {
        CFG_PAL_REGION   = 2'd0,
        CFG_INTERLACE_ON = 2'd1,
        CFG_OVERSCAN_ON  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        func_t       func;
        logic [9:0]  nmi_vpos;
        logic [9:0]  irq_vpos;
        logic [11:0] irq_hpos;
        logic [7:0]  enable_byte;
        logic [8:0]  vtime_value;
        logic [8:0]  htime_value;
        logic        cpu_irq_disable;
    } item_t;

    typedef struct packed {
        logic answer;
        logic wake;
        logic nmi_level;
        logic irq_level;
    } result_t;

    typedef struct packed {
        logic       en;
        cfg_index_t index;
        logic       data;
    } cfg_wr_t;

    localparam logic [9:0]  VBLANK_LINE          = 10'd225;
    localparam logic [9:0]  VBLANK_LINE_OVERSCAN = 10'd240;
    localparam logic [8:0]  LAST_LINE_525        = 9'd262;
    localparam logic [8:0]  LAST_LINE_625        = 9'd312;
    localparam logic [8:0]  LAST_DOT             = 9'd339;
    localparam logic [9:0]  V_TRIGGER_NONE       = 10'h3ff;
    localparam logic [11:0] H_TRIGGER_NONE       = 12'hfff;
    localparam logic [2:0]  HOLD_START           = 3'd4;
    localparam logic [2:0]  HOLD_STEP            = 3'd2;

    localparam int EN_BIT_NMI  = 7;
    localparam int EN_BIT_VIRQ = 5;
    localparam int EN_BIT_HIRQ = 4;

endpackage

[rtl/hvc_in_stage.sv]
// Input register of the video-counter interrupt unit.
// Depends on hvc_pkg for the item word type.
module hvc_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  hvc_pkg::item_t item,
    input  logic          advance,
    output logic          s1_valid,
    output hvc_pkg::item_t s1_item
);

    logic           valid_reg;
    logic           valid_next;
    hvc_pkg::item_t item_reg;
    logic           take;

    // Hold the word while the engine cannot move it on.
    assign item_stall = valid_reg && !advance;
    assign take       = item_valid && !item_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

[rtl/hvc_engine.sv]
// Interrupt state and per-word update logic of the video-counter interrupt unit.
// Depends on hvc_pkg for item, result and configuration types and constants.
module hvc_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  hvc_pkg::cfg_wr_t cfg_wr,
    input  logic             fire,
    input  hvc_pkg::item_t   s1_item,
    output hvc_pkg::result_t step_result
);

    logic        pal_reg, interlace_reg, overscan_reg;

    logic        nmi_enable_reg, virq_enable_reg, hirq_enable_reg;
    logic        nmi_flag_reg, irq_flag_reg, nmi_pending_reg, irq_pending_reg;
    logic        nmi_prev_reg, irq_prev_reg;
    logic [2:0]  nmi_count_reg, irq_count_reg;
    logic [8:0]  vtime_reg, htime_reg;
    logic [9:0]  v_trigger_reg;
    logic [11:0] h_trigger_reg;

    logic        nmi_enable_next, virq_enable_next, hirq_enable_next;
    logic        nmi_flag_next, irq_flag_next, nmi_pending_next, irq_pending_next;
    logic        nmi_prev_next, irq_prev_next;
    logic [2:0]  nmi_count_next, irq_count_next;
    logic [8:0]  vtime_next, htime_next;
    logic [9:0]  v_trigger_next;
    logic [11:0] h_trigger_next;

    logic        answer, wake;
    logic        nmi_in_vblank, irq_at_point;

    function automatic logic [2:0] hold_down(input logic [2:0] h);
        hold_down = (h >= hvc_pkg::HOLD_STEP) ? (h - hvc_pkg::HOLD_STEP) : 3'd0;
    endfunction

    // Trigger points from the programmed line/dot; last dot of a field never fires.
    function automatic logic [21:0] triggers(input logic [8:0] vt,
                                             input logic [8:0] htime,
                                             input logic       hirq,
                                             input logic       pal,
                                             input logic       interlace);
        logic [8:0]  ht;
        logic [8:0]  last;
        logic [9:0]  ht_inc;
        logic [9:0]  vtrig;
        logic [11:0] htrig;
        ht     = hirq ? htime : 9'd0;
        last   = pal ? hvc_pkg::LAST_LINE_625 : hvc_pkg::LAST_LINE_525;
        ht_inc = {1'b0, ht} + 10'd1;
        vtrig  = {1'b0, vt};
        htrig  = hirq ? {ht_inc, 2'b00} : 12'd0;
        if (ht == hvc_pkg::LAST_DOT &&
            ((vt == last - 9'd1 && !interlace) || vt == last))
        begin
            vtrig = hvc_pkg::V_TRIGGER_NONE;
            htrig = hvc_pkg::H_TRIGGER_NONE;
        end
        triggers = {vtrig, htrig};
    endfunction

    always_comb
    begin
        nmi_enable_next  = nmi_enable_reg;
        virq_enable_next = virq_enable_reg;
        hirq_enable_next = hirq_enable_reg;
        nmi_flag_next    = nmi_flag_reg;
        irq_flag_next    = irq_flag_reg;
        nmi_pending_next = nmi_pending_reg;
        irq_pending_next = irq_pending_reg;
        nmi_prev_next    = nmi_prev_reg;
        irq_prev_next    = irq_prev_reg;
        nmi_count_next   = nmi_count_reg;
        irq_count_next   = irq_count_reg;
        vtime_next       = vtime_reg;
        htime_next       = htime_reg;
        v_trigger_next   = v_trigger_reg;
        h_trigger_next   = h_trigger_reg;
        answer           = 1'b0;
        wake             = 1'b0;
        nmi_in_vblank    = 1'b0;
        irq_at_point     = 1'b0;

        case (s1_item.func)
            hvc_pkg::FUNC_POLL:
            begin
                if (nmi_count_reg != 3'd0)
                begin
                    nmi_count_next = hold_down(nmi_count_reg);
                    if (nmi_count_next == 3'd0 && nmi_enable_reg)
                    begin
                        nmi_pending_next = 1'b1;
                    end
                end
                nmi_in_vblank = s1_item.nmi_vpos >= (overscan_reg ?
                                hvc_pkg::VBLANK_LINE_OVERSCAN : hvc_pkg::VBLANK_LINE);
                if (!nmi_prev_reg && nmi_in_vblank)
                begin
                    nmi_flag_next  = 1'b1;
                    nmi_count_next = hvc_pkg::HOLD_START;
                end
                else if (nmi_prev_reg && !nmi_in_vblank)
                begin
                    nmi_flag_next = 1'b0;
                end
                nmi_prev_next = nmi_in_vblank;

                irq_count_next = hold_down(irq_count_reg);
                if (irq_flag_reg && irq_count_next == 3'd0 &&
                    (virq_enable_reg || hirq_enable_reg))
                begin
                    irq_pending_next = 1'b1;
                end
                irq_at_point = (virq_enable_reg || hirq_enable_reg) &&
                               !(virq_enable_reg && s1_item.irq_vpos != v_trigger_reg) &&
                               !(hirq_enable_reg && s1_item.irq_hpos != h_trigger_reg);
                if (!irq_prev_reg && irq_at_point)
                begin
                    irq_flag_next  = 1'b1;
                    irq_count_next = hvc_pkg::HOLD_START;
                end
                irq_prev_next = irq_at_point;
            end
            hvc_pkg::FUNC_ENABLE_WR:
            begin
                nmi_enable_next  = s1_item.enable_byte[hvc_pkg::EN_BIT_NMI];
                virq_enable_next = s1_item.enable_byte[hvc_pkg::EN_BIT_VIRQ];
                hirq_enable_next = s1_item.enable_byte[hvc_pkg::EN_BIT_HIRQ];
                if (!nmi_enable_reg && nmi_enable_next && nmi_flag_reg)
                begin
                    nmi_pending_next = 1'b1;
                end
                if (virq_enable_next && !hirq_enable_next && irq_flag_reg)
                begin
                    irq_pending_next = 1'b1;
                end
                if (!virq_enable_next && !hirq_enable_next)
                begin
                    irq_flag_next    = 1'b0;
                    irq_pending_next = 1'b0;
                end
                {v_trigger_next, h_trigger_next} = triggers(vtime_reg, htime_reg,
                    hirq_enable_next, pal_reg, interlace_reg);
            end
            hvc_pkg::FUNC_POS_WR:
            begin
                vtime_next = s1_item.vtime_value;
                htime_next = s1_item.htime_value;
                {v_trigger_next, h_trigger_next} = triggers(vtime_next, htime_next,
                    hirq_enable_reg, pal_reg, interlace_reg);
            end
            hvc_pkg::FUNC_NMI_READ:
            begin
                answer = nmi_flag_reg;
                if (nmi_count_reg == 3'd0)
                begin
                    nmi_flag_next = 1'b0;
                end
            end
            hvc_pkg::FUNC_IRQ_READ:
            begin
                answer = irq_flag_reg;
                if (irq_count_reg == 3'd0)
                begin
                    irq_flag_next    = 1'b0;
                    irq_pending_next = 1'b0;
                end
            end
            hvc_pkg::FUNC_NMI_TAKE:
            begin
                if (nmi_pending_reg)
                begin
                    nmi_pending_next = 1'b0;
                    wake             = 1'b1;
                    answer           = 1'b1;
                end
            end
            hvc_pkg::FUNC_IRQ_TAKE:
            begin
                if (irq_pending_reg)
                begin
                    irq_pending_next = 1'b0;
                    wake             = 1'b1;
                    answer           = !s1_item.cpu_irq_disable;
                end
            end
            default:
            begin
                answer = 1'b0;
            end
        endcase
    end

    assign step_result.answer    = answer;
    assign step_result.wake      = wake;
    assign step_result.nmi_level = nmi_flag_next;
    assign step_result.irq_level = irq_flag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_reg       <= 1'b0;
            interlace_reg <= 1'b0;
            overscan_reg  <= 1'b0;
        end
        else if (cfg_wr.en)
        begin
            case (cfg_wr.index)
                hvc_pkg::CFG_PAL_REGION:   pal_reg       <= cfg_wr.data;
                hvc_pkg::CFG_INTERLACE_ON: interlace_reg <= cfg_wr.data;
                hvc_pkg::CFG_OVERSCAN_ON:  overscan_reg  <= cfg_wr.data;
                default:                   pal_reg       <= pal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nmi_enable_reg  <= 1'b0;
            virq_enable_reg <= 1'b0;
            hirq_enable_reg <= 1'b0;
            nmi_flag_reg    <= 1'b0;
            irq_flag_reg    <= 1'b0;
            nmi_pending_reg <= 1'b0;
            irq_pending_reg <= 1'b0;
            nmi_prev_reg    <= 1'b0;
            irq_prev_reg    <= 1'b0;
            nmi_count_reg   <= 3'd0;
            irq_count_reg   <= 3'd0;
            vtime_reg       <= 9'd0;
            htime_reg       <= 9'd0;
            v_trigger_reg   <= 10'd0;
            h_trigger_reg   <= 12'd0;
        end
        else if (fire)
        begin
            nmi_enable_reg  <= nmi_enable_next;
            virq_enable_reg <= virq_enable_next;
            hirq_enable_reg <= hirq_enable_next;
            nmi_flag_reg    <= nmi_flag_next;
            irq_flag_reg    <= irq_flag_next;
            nmi_pending_reg <= nmi_pending_next;
            irq_pending_reg <= irq_pending_next;
            nmi_prev_reg    <= nmi_prev_next;
            irq_prev_reg    <= irq_prev_next;
            nmi_count_reg   <= nmi_count_next;
            irq_count_reg   <= irq_count_next;
            vtime_reg       <= vtime_next;
            htime_reg       <= htime_next;
            v_trigger_reg   <= v_trigger_next;
            h_trigger_reg   <= h_trigger_next;
        end
    end

endmodule

[rtl/hv_counter_irq_nmi_unit.sv]
// Top level of the video-counter interrupt unit: input register, engine, result register.
// Depends on hvc_pkg, hvc_in_stage and hvc_engine.

// Takes one word per clock when the result side does not stall, and returns one result word
// per input word. The rate is set by the state update in the engine, which sits between the
// input register and the result register; a new word enters while the previous result still
// waits to be taken. Configuration writes are accepted in every cycle and take effect on
// the next word.
module hv_counter_irq_nmi_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  hvc_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output hvc_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic             cfg_data
);

    logic             s1_valid;
    hvc_pkg::item_t   s1_item;
    logic             advance;
    logic             fire;
    hvc_pkg::cfg_wr_t cfg_wr;
    hvc_pkg::result_t step_result;

    logic             result_valid_reg;
    logic             result_valid_next;
    hvc_pkg::result_t result_reg;

    // Move on whenever the result register is free or being emptied.
    assign advance = !result_valid_reg || !result_stall;
    assign fire    = s1_valid && advance;

    assign cfg_ready     = 1'b1;
    assign cfg_wr.en     = cfg_valid && cfg_ready;
    assign cfg_wr.index  = hvc_pkg::cfg_index_t'(cfg_index);
    assign cfg_wr.data   = cfg_data;

    hvc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .advance    (advance),
        .s1_valid   (s1_valid),
        .s1_item    (s1_item)
    );

    hvc_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_wr),
        .fire        (fire),
        .s1_item     (s1_item),
        .step_result (step_result)
    );

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = s1_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[rtl/hvc_checker.sv]
// Port-level checker for the video-counter interrupt unit, bound to the top level.
// Depends on hvc_pkg and hv_counter_irq_nmi_unit_defines.svh.
`include "hv_counter_irq_nmi_unit_defines.svh"

module hvc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input hvc_pkg::result_t result,
    input logic             result_valid,
    input logic             result_stall
);

    logic item_take;
    logic result_held;

    assign item_take   = item_valid && !item_stall;
    assign result_held = result_valid && result_stall;

    // A stalled result word holds.
    `HVC_ASSERT_NEXT(a_result_hold, clk, rst_n, result_held, result_valid && $stable(result))

    // Input backs up only behind a blocked result.
    `HVC_ASSERT_SAME(a_stall_cause, clk, rst_n, item_stall, result_valid && result_stall)

    // Acceptance of a word is followed by a valid word at the result side.
    `HVC_ASSERT_NEXT(a_result_follows, clk, rst_n, item_take, ##1 result_valid)

endmodule

bind hv_counter_irq_nmi_unit hvc_checker u_hvc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
);

[tb/sv/hv_counter_irq_nmi_unit_checker.sv]
// Checker for the video-counter interrupt unit: predicts every result word and compares.
// Depends on hvc_pkg; instantiated beside the block by hv_counter_irq_nmi_unit_tb.
module hv_counter_irq_nmi_unit_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  hvc_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_stall,
    input  hvc_pkg::result_t result,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic             cfg_data,
    output int               error_count,
    output int               words_in_flight
);

    // Configuration copy
    logic pal, ilace, oscan;

    // Interrupt state
    logic        nmi_en, virq_en, hirq_en;
    logic        nmi_flag, irq_flag, nmi_pend, irq_pend;
    logic        in_vblank_prev, at_trigger_prev;
    logic [2:0]  nmi_count, irq_count;
    logic [8:0]  vtime, htime;
    logic [9:0]  v_trig;
    logic [11:0] h_trig;

    hvc_pkg::result_t irq_nmi_outcomes[$];
    hvc_pkg::result_t want;

    function automatic logic [2:0] hold_down(logic [2:0] h);
        return (h >= hvc_pkg::HOLD_STEP) ? h - hvc_pkg::HOLD_STEP : 3'd0;
    endfunction

    function automatic void refresh_triggers();
        logic [9:0]  vt;
        logic [9:0]  ht;
        logic [9:0]  last;
        logic [13:0] hs;
        vt = {1'b0, vtime};
        ht = hirq_en ? {1'b0, htime} : 10'd0;
        last = pal ? {1'b0, hvc_pkg::LAST_LINE_625} : {1'b0, hvc_pkg::LAST_LINE_525};
        // drop a trigger on the last dot of the field
        if ((vt == last - 10'd1 && ht == hvc_pkg::LAST_DOT && !ilace) ||
            (vt == last && ht == hvc_pkg::LAST_DOT))
        begin
            vt = hvc_pkg::V_TRIGGER_NONE;
            ht = hvc_pkg::V_TRIGGER_NONE;
        end
        v_trig = vt;
        hs = hirq_en ? 14'(4 * ({4'd0, ht} + 14'd1)) : 14'd0;
        h_trig = (hs > 14'(hvc_pkg::H_TRIGGER_NONE)) ? hvc_pkg::H_TRIGGER_NONE : hs[11:0];
    endfunction

    function automatic hvc_pkg::result_t step_interrupt_unit(hvc_pkg::item_t w);
        hvc_pkg::result_t r;
        logic             in_vblank;
        logic             at_trigger;
        r = '0;
        case (w.func)
            hvc_pkg::FUNC_POLL:
            begin
                if (nmi_count != 3'd0)
                begin
                    nmi_count = hold_down(nmi_count);
                    if (nmi_count == 3'd0 && nmi_en)
                        nmi_pend = 1'b1;
                end
                in_vblank = w.nmi_vpos >= (oscan ? hvc_pkg::VBLANK_LINE_OVERSCAN :
                                                   hvc_pkg::VBLANK_LINE);
                if (!in_vblank_prev && in_vblank)
                begin
                    nmi_flag = 1'b1;
                    nmi_count = hvc_pkg::HOLD_START;
                end
                else if (in_vblank_prev && !in_vblank)
                    nmi_flag = 1'b0;
                in_vblank_prev = in_vblank;

                if (irq_count != 3'd0)
                    irq_count = hold_down(irq_count);
                if (irq_flag && irq_count == 3'd0 && (virq_en || hirq_en))
                    irq_pend = 1'b1;
                at_trigger = virq_en || hirq_en;
                if (virq_en && w.irq_vpos != v_trig)
                    at_trigger = 1'b0;
                if (hirq_en && w.irq_hpos != h_trig)
                    at_trigger = 1'b0;
                if (!at_trigger_prev && at_trigger)
                begin
                    irq_flag = 1'b1;
                    irq_count = hvc_pkg::HOLD_START;
                end
                at_trigger_prev = at_trigger;
            end
            hvc_pkg::FUNC_ENABLE_WR:
            begin
                if (!nmi_en && w.enable_byte[hvc_pkg::EN_BIT_NMI] && nmi_flag)
                    nmi_pend = 1'b1;
                nmi_en = w.enable_byte[hvc_pkg::EN_BIT_NMI];
                virq_en = w.enable_byte[hvc_pkg::EN_BIT_VIRQ];
                hirq_en = w.enable_byte[hvc_pkg::EN_BIT_HIRQ];
                if (virq_en && !hirq_en && irq_flag)
                    irq_pend = 1'b1;
                if (!virq_en && !hirq_en)
                begin
                    irq_flag = 1'b0;
                    irq_pend = 1'b0;
                end
                refresh_triggers();
            end
            hvc_pkg::FUNC_POS_WR:
            begin
                vtime = w.vtime_value;
                htime = w.htime_value;
                refresh_triggers();
            end
            hvc_pkg::FUNC_NMI_READ:
            begin
                r.answer = nmi_flag;
                if (nmi_count == 3'd0)
                    nmi_flag = 1'b0;
            end
            hvc_pkg::FUNC_IRQ_READ:
            begin
                r.answer = irq_flag;
                if (irq_count == 3'd0)
                begin
                    irq_flag = 1'b0;
                    irq_pend = 1'b0;
                end
            end
            hvc_pkg::FUNC_NMI_TAKE:
            begin
                if (nmi_pend)
                begin
                    nmi_pend = 1'b0;
                    r.wake = 1'b1;
                    r.answer = 1'b1;
                end
            end
            hvc_pkg::FUNC_IRQ_TAKE:
            begin
                if (irq_pend)
                begin
                    irq_pend = 1'b0;
                    r.wake = 1'b1;
                    r.answer = !w.cpu_irq_disable;
                end
            end
            default: ;
        endcase
        r.nmi_level = nmi_flag;
        r.irq_level = irq_flag;
        return r;
    endfunction

    function automatic void compare_bit(string field, logic exp_b, logic act_b);
        if (exp_b !== act_b)
        begin
            $display("%0t: %s mismatch, expected %b, actual %b", $time, field, exp_b, act_b);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal = 1'b0;
            ilace = 1'b0;
            oscan = 1'b0;
            nmi_en = 1'b0;
            virq_en = 1'b0;
            hirq_en = 1'b0;
            nmi_flag = 1'b0;
            irq_flag = 1'b0;
            nmi_pend = 1'b0;
            irq_pend = 1'b0;
            in_vblank_prev = 1'b0;
            at_trigger_prev = 1'b0;
            nmi_count = 3'd0;
            irq_count = 3'd0;
            vtime = 9'd0;
            htime = 9'd0;
            v_trig = 10'd0;
            h_trig = 12'd0;
            irq_nmi_outcomes.delete();
            error_count = 0;
            words_in_flight <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hvc_pkg::CFG_PAL_REGION:   pal = cfg_data;
                    hvc_pkg::CFG_INTERLACE_ON: ilace = cfg_data;
                    hvc_pkg::CFG_OVERSCAN_ON:  oscan = cfg_data;
                    default: ;
                endcase
            end
            // retire the oldest prediction before queuing this edge's word
            if (result_valid && !result_stall)
            begin
                if (irq_nmi_outcomes.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, expected none, actual %b",
                             $time, result);
                    error_count++;
                end
                else
                begin
                    want = irq_nmi_outcomes.pop_front();
                    compare_bit("answer", want.answer, result.answer);
                    compare_bit("wake", want.wake, result.wake);
                    compare_bit("nmi_level", want.nmi_level, result.nmi_level);
                    compare_bit("irq_level", want.irq_level, result.irq_level);
                end
            end
            if (item_valid && !item_stall)
                irq_nmi_outcomes.push_back(step_interrupt_unit(item));
            words_in_flight <= irq_nmi_outcomes.size();
        end
    end

endmodule

[tb/sv/hv_counter_irq_nmi_unit_tb.sv]
// Top of the video-counter interrupt unit testbench: clock, reset, stimulus and verdict.
// Depends on hvc_pkg, hv_counter_irq_nmi_unit and hv_counter_irq_nmi_unit_checker.
module hv_counter_irq_nmi_unit_tb;

    localparam hvc_pkg::func_t FUNC_UNUSED = hvc_pkg::func_t'(3'd7);
    localparam int             CYCLE_LIMIT = 200000;
    localparam int             PHASE_WORDS = 185;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    hvc_pkg::item_t   item;
    logic             result_valid;
    logic             result_stall;
    hvc_pkg::result_t result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic             cfg_data;

    int error_count;
    int words_in_flight;
    int cycle_count;

    logic       tx_idle_on;
    logic       rx_idle_on;
    logic [8:0] aim_vtime;
    logic [8:0] aim_htime;

    hv_counter_irq_nmi_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    hv_counter_irq_nmi_unit_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .words_in_flight (words_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("hv_counter_irq_nmi_unit test failed");
        $finish;
    end

    // Result side: with rx_idle_on set, stall a random number of cycles before taking each word
    initial
    begin
        int n;
        result_stall <= 1'b0;
        forever
        begin
            n = rx_idle_on ? $urandom_range(0, 4) : 0;
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (result_valid !== 1'b1)
                @(posedge clk);
        end
    end

    task automatic send_word(hvc_pkg::item_t w);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic wait_until_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (words_in_flight != 0)
            @(posedge clk);
    endtask

    task automatic put_register(hvc_pkg::cfg_index_t idx, logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_config(logic [2:0] mode);
        put_register(hvc_pkg::CFG_PAL_REGION, mode[2]);
        put_register(hvc_pkg::CFG_INTERLACE_ON, mode[1]);
        put_register(hvc_pkg::CFG_OVERSCAN_ON, mode[0]);
        cfg_valid <= 1'b0;
    endtask

    function automatic hvc_pkg::item_t blank_word(hvc_pkg::func_t f);
        hvc_pkg::item_t w;
        w = '0;
        w.func = f;
        return w;
    endfunction

    function automatic hvc_pkg::item_t poll_word(logic [9:0] nv, logic [9:0] iv,
                                                 logic [11:0] ih);
        hvc_pkg::item_t w;
        w = blank_word(hvc_pkg::FUNC_POLL);
        w.nmi_vpos = nv;
        w.irq_vpos = iv;
        w.irq_hpos = ih;
        return w;
    endfunction

    function automatic hvc_pkg::item_t enable_word(logic [7:0] b);
        hvc_pkg::item_t w;
        w = blank_word(hvc_pkg::FUNC_ENABLE_WR);
        w.enable_byte = b;
        return w;
    endfunction

    function automatic hvc_pkg::item_t position_word(logic [8:0] v, logic [8:0] h);
        hvc_pkg::item_t w;
        w = blank_word(hvc_pkg::FUNC_POS_WR);
        w.vtime_value = v;
        w.htime_value = h;
        return w;
    endfunction

    // Random word: unused fields carry noise, polls aim at the vblank edge and the trigger
    function automatic hvc_pkg::item_t random_word();
        hvc_pkg::item_t w;
        int             pick;
        w.nmi_vpos = 10'($urandom);
        w.irq_vpos = 10'($urandom);
        w.irq_hpos = 12'($urandom);
        w.enable_byte = 8'($urandom);
        w.vtime_value = 9'($urandom);
        w.htime_value = 9'($urandom);
        w.cpu_irq_disable = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            w.func = hvc_pkg::FUNC_POLL;
            pick = $urandom_range(0, 9);
            w.nmi_vpos = (pick < 4) ? 10'($urandom_range(0, 224)) :
                         (pick < 8) ? 10'($urandom_range(240, 1023)) :
                         (pick == 8) ? 10'(224 + $urandom_range(0, 1)) :
                                       10'(239 + $urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            if (pick < 5)
                w.irq_vpos = {1'b0, aim_vtime};
            else if (pick == 5)
                w.irq_vpos = hvc_pkg::V_TRIGGER_NONE;
            pick = $urandom_range(0, 9);
            if (pick < 5)
                w.irq_hpos = 12'(4 * ({3'd0, aim_htime} + 12'd1));
            else if (pick == 5)
                w.irq_hpos = hvc_pkg::H_TRIGGER_NONE;
        end
        else if (pick < 60)
            w.func = hvc_pkg::FUNC_ENABLE_WR;
        else if (pick < 68)
        begin
            w.func = hvc_pkg::FUNC_POS_WR;
            pick = $urandom_range(0, 7);
            if (pick < 2)
            begin
                w.vtime_value = (pick == 0) ?
                    9'(hvc_pkg::LAST_LINE_525 - 1 + $urandom_range(0, 1)) :
                    9'(hvc_pkg::LAST_LINE_625 - 1 + $urandom_range(0, 1));
                w.htime_value = hvc_pkg::LAST_DOT;
            end
            else if (pick < 5)
                w.vtime_value = 9'($urandom_range(0, 15));
            aim_vtime = w.vtime_value;
            aim_htime = w.htime_value;
        end
        else if (pick < 76)
            w.func = hvc_pkg::FUNC_NMI_READ;
        else if (pick < 84)
            w.func = hvc_pkg::FUNC_IRQ_READ;
        else if (pick < 91)
            w.func = hvc_pkg::FUNC_NMI_TAKE;
        else if (pick < 98)
            w.func = hvc_pkg::FUNC_IRQ_TAKE;
        else
            w.func = FUNC_UNUSED;
        return w;
    endfunction

    initial
    begin
        logic [2:0]     modes [6];
        hvc_pkg::item_t w;
        modes = '{3'b000, 3'b111, 3'b100, 3'b011, 3'b010, 3'b101};
        rst_n = 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= hvc_pkg::CFG_PAL_REGION;
        cfg_data <= 1'b0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        aim_vtime = 9'd0;
        aim_htime = 9'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_config(3'b000);
        send_word(poll_word(10'd0, 10'd0, 12'd0));
        w = '1;
        w.func = hvc_pkg::FUNC_POLL;
        send_word(w);
        send_word(poll_word(10'd0, 10'd0, 12'd0));
        // vblank NMI: edge, hold countdown, pending, take, read
        send_word(enable_word(8'h80));
        send_word(poll_word(hvc_pkg::VBLANK_LINE, 10'd0, 12'd0));
        send_word(blank_word(hvc_pkg::FUNC_NMI_READ));
        send_word(poll_word(10'd300, 10'd0, 12'd0));
        send_word(poll_word(10'd300, 10'd0, 12'd0));
        send_word(blank_word(hvc_pkg::FUNC_NMI_TAKE));
        send_word(blank_word(hvc_pkg::FUNC_NMI_TAKE));
        send_word(blank_word(hvc_pkg::FUNC_NMI_READ));
        // V-only IRQ, then a masked take
        send_word(position_word(9'd5, 9'd0));
        send_word(enable_word(8'h20));
        send_word(poll_word(10'd0, 10'd5, 12'd0));
        send_word(poll_word(10'd0, 10'd6, 12'd0));
        send_word(poll_word(10'd0, 10'd6, 12'd0));
        w = blank_word(hvc_pkg::FUNC_IRQ_TAKE);
        w.cpu_irq_disable = 1'b1;
        send_word(w);
        send_word(blank_word(hvc_pkg::FUNC_IRQ_READ));
        // last dot of the field: trigger moves out of reach; the largest H position gives 12'h800
        send_word(enable_word(8'h30));
        send_word(position_word(9'(hvc_pkg::LAST_LINE_525), hvc_pkg::LAST_DOT));
        send_word(poll_word(10'd0, hvc_pkg::V_TRIGGER_NONE, hvc_pkg::H_TRIGGER_NONE));
        send_word(position_word(9'h1ff, 9'h1ff));
        send_word(poll_word(10'd0, 10'h1ff, 12'h800));
        send_word(enable_word(8'h00));
        send_word(blank_word(hvc_pkg::FUNC_IRQ_TAKE));
        send_word(blank_word(FUNC_UNUSED));

        for (int phase = 0; phase < 6; phase++)
        begin
            wait_until_drained();
            write_config(modes[phase]);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (n % 40 == 0)
                begin
                    tx_idle_on = ($urandom_range(0, 2) != 0);
                    rx_idle_on = ($urandom_range(0, 2) != 0);
                end
                send_word(random_word());
            end
        end

        wait_until_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("hv_counter_irq_nmi_unit test passed");
        else
            $display("hv_counter_irq_nmi_unit test failed");
        $finish;
    end

endmodule
